[design/twtp_pkg.sv]
// ----------------------------------------------------------------------------
// Two-way traffic phase controller package
// Phase encoding, lamp patterns, seven-segment codes and register defaults
// shared by the controller modules.
// ----------------------------------------------------------------------------
package twtp_pkg;

    // Number of duration registers, four per direction.
    localparam int NUM_TIMES = 8;

    // Highest value shown on the two-digit display.
    localparam int DISPLAY_MAX = 99;

    // Reset values of the duration registers, in register order.
    localparam int TIME_RESET [NUM_TIMES] = '{35, 20, 10, 5, 35, 20, 10, 5};

    // Signal phase of one direction, one-hot.
    typedef enum logic [3:0] {
        PH_RED    = 4'b0001,
        PH_GREEN  = 4'b0010,
        PH_LEFT   = 4'b0100,
        PH_YELLOW = 4'b1000
    } phase_t;

    // External phase codes.
    localparam logic [1:0] CODE_RED    = 2'd0;
    localparam logic [1:0] CODE_GREEN  = 2'd1;
    localparam logic [1:0] CODE_LEFT   = 2'd2;
    localparam logic [1:0] CODE_YELLOW = 2'd3;

    // Lamp patterns: bit0 red, bit1 yellow, bit2 green, bit3 left, bit4 right.
    localparam logic [4:0] LAMP_RED    = 5'h11;
    localparam logic [4:0] LAMP_GREEN  = 5'h14;
    localparam logic [4:0] LAMP_LEFT   = 5'h0C;
    localparam logic [4:0] LAMP_YELLOW = 5'h0A;

    // Input command kinds.
    localparam logic CMD_TICK   = 1'b0;
    localparam logic CMD_RELOAD = 1'b1;

    // Convert a one-hot phase to its external code.
    function automatic logic [1:0] phase_code(input phase_t ph);
        logic [1:0] code;
        case (ph)
            PH_RED:    code = CODE_RED;
            PH_GREEN:  code = CODE_GREEN;
            PH_LEFT:   code = CODE_LEFT;
            PH_YELLOW: code = CODE_YELLOW;
            default:   code = CODE_YELLOW;
        endcase
        return code;
    endfunction

    // Lamp pattern of a phase.
    function automatic logic [4:0] phase_lamps(input phase_t ph);
        logic [4:0] lamps;
        case (ph)
            PH_RED:    lamps = LAMP_RED;
            PH_GREEN:  lamps = LAMP_GREEN;
            PH_LEFT:   lamps = LAMP_LEFT;
            PH_YELLOW: lamps = LAMP_YELLOW;
            default:   lamps = LAMP_YELLOW;
        endcase
        return lamps;
    endfunction

    // Seven-segment code (gfedcba) of one decimal digit.
    function automatic logic [6:0] seg_code(input logic [3:0] digit);
        logic [6:0] seg;
        case (digit)
            4'd0:    seg = 7'h3f;
            4'd1:    seg = 7'h06;
            4'd2:    seg = 7'h5b;
            4'd3:    seg = 7'h4f;
            4'd4:    seg = 7'h66;
            4'd5:    seg = 7'h6d;
            4'd6:    seg = 7'h7d;
            4'd7:    seg = 7'h07;
            4'd8:    seg = 7'h7f;
            4'd9:    seg = 7'h6f;
            default: seg = 7'h3f;
        endcase
        return seg;
    endfunction

endpackage

[design/twtp_regs.sv]
// ----------------------------------------------------------------------------
// Duration registers
// APB-style register file for the eight phase durations, plus the active
// durations that the sequencers use, copied over on a reload.
// ----------------------------------------------------------------------------
module twtp_regs
    import twtp_pkg::*;
#(
    parameter int TIME_BITS = 7
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [4:0]                           paddr,
    input  logic [31:0]                          pwdata,
    output logic [31:0]                          prdata,
    input  logic                                 load,
    output logic [NUM_TIMES-1:0][TIME_BITS-1:0]  active
);

    logic [NUM_TIMES-1:0][TIME_BITS-1:0] cfg_reg;
    logic [NUM_TIMES-1:0][TIME_BITS-1:0] cfg_next;
    logic [NUM_TIMES-1:0][TIME_BITS-1:0] active_reg;
    logic [NUM_TIMES-1:0][TIME_BITS-1:0] active_next;
    logic [2:0]                          reg_idx;
    logic                                wr_en;

    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;

    // Register write decode.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            cfg_next[reg_idx] = pwdata[TIME_BITS-1:0];
        end
    end

    // Active durations follow the registers only on a reload.
    always_comb
    begin
        active_next = active_reg;
        if (load)
        begin
            active_next = cfg_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_TIMES; i++)
            begin
                cfg_reg[i]    <= TIME_BITS'(TIME_RESET[i]);
                active_reg[i] <= TIME_BITS'(TIME_RESET[i]);
            end
        end
        else
        begin
            cfg_reg    <= cfg_next;
            active_reg <= active_next;
        end
    end

    assign prdata = 32'(cfg_reg[reg_idx]);
    assign active = active_reg;

endmodule

[design/twtp_sequencer.sv]
// ----------------------------------------------------------------------------
// Phase sequencer
// Four-phase signal sequencer for one direction: phase, tick counter and
// held remaining-ticks value, advanced by one tick per step.
// ----------------------------------------------------------------------------
module twtp_sequencer
    import twtp_pkg::*;
#(
    parameter int     TIME_BITS   = 7,
    parameter phase_t RESET_PHASE = PH_RED,
    localparam int    CW          = TIME_BITS + 1
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        step,
    input  logic [3:0][TIME_BITS-1:0]   times,
    output phase_t                      phase,
    output phase_t                      phase_now,
    output logic [CW-1:0]               rem_now,
    output logic                        count_zero
);

    phase_t        phase_reg;
    phase_t        phase_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [CW-1:0] held_reg;
    logic [CW-1:0] rem_calc;
    logic [CW-1:0] cnt_inc;
    logic [CW-1:0] red_end;
    logic [CW-1:0] straight_end;
    logic [CW-1:0] green_end;
    logic [CW-1:0] yellow_end;

    // Ticks left until the end of an interval, zero once past it.
    function automatic logic [CW-1:0] left_of(input logic [CW-1:0] end_val,
                                              input logic [CW-1:0] c);
        return (c > end_val) ? '0 : end_val - c;
    endfunction

    assign cnt_inc      = count_reg + CW'(1);
    assign red_end      = CW'(times[0]);
    assign straight_end = CW'(times[1]);
    assign green_end    = CW'(times[1]) + CW'(times[2]);
    assign yellow_end   = CW'(times[3]);

    // Next phase, counter and remaining ticks for one tick.
    always_comb
    begin
        phase_next = phase_reg;
        count_next = cnt_inc;
        rem_calc   = '0;
        case (phase_reg)
            PH_RED:
            begin
                if (cnt_inc == red_end)
                begin
                    count_next = '0;
                    phase_next = PH_GREEN;
                end
                else
                begin
                    rem_calc = left_of(red_end, cnt_inc);
                end
            end
            PH_GREEN:
            begin
                // The counter keeps running into the left-turn phase.
                if (cnt_inc == straight_end)
                begin
                    phase_next = PH_LEFT;
                end
                rem_calc = left_of(green_end, cnt_inc);
            end
            PH_LEFT:
            begin
                if (cnt_inc == green_end)
                begin
                    count_next = '0;
                    phase_next = PH_YELLOW;
                end
                else
                begin
                    rem_calc = left_of(green_end, cnt_inc);
                end
            end
            PH_YELLOW:
            begin
                if (cnt_inc == yellow_end)
                begin
                    count_next = '0;
                    phase_next = PH_RED;
                end
                else
                begin
                    rem_calc = left_of(yellow_end, cnt_inc);
                end
            end
            default:
            begin
                count_next = '0;
                phase_next = RESET_PHASE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= RESET_PHASE;
            count_reg <= '0;
            held_reg  <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            held_reg  <= rem_calc;
        end
    end

    // State as it stands after this item.
    assign phase      = phase_reg;
    assign phase_now  = step ? phase_next : phase_reg;
    assign rem_now    = step ? rem_calc : held_reg;
    assign count_zero = step ? (count_next == '0) : (count_reg == '0);

endmodule

[design/twtp_display.sv]
// ----------------------------------------------------------------------------
// Display digit decoder
// Picks the scanned direction and digit, saturates the value at 99 and
// returns its seven-segment code.
// ----------------------------------------------------------------------------
module twtp_display
    import twtp_pkg::*;
#(
    parameter int VALUE_BITS = 8
)
(
    input  logic [VALUE_BITS-1:0] ew_value,
    input  logic [VALUE_BITS-1:0] ns_value,
    input  logic [2:0]            digit_position,
    output logic [6:0]            segments
);

    logic [VALUE_BITS-1:0] sel_value;
    logic [6:0]            sat_value;
    logic [14:0]           tens_prod;
    logic [3:0]            tens;
    logic [6:0]            tens_x10;
    logic [3:0]            ones;

    // Positions 0 to 3 show east-west, 4 to 7 north-south.
    assign sel_value = digit_position[2] ? ns_value : ew_value;
    assign sat_value = (sel_value > VALUE_BITS'(DISPLAY_MAX)) ? 7'(DISPLAY_MAX)
                                                              : 7'(sel_value);

    // Divide by ten through the reciprocal 205/2048, exact below 180.
    assign tens_prod = 15'(sat_value) * 15'd205;
    assign tens      = tens_prod[14:11];
    assign tens_x10  = 7'({tens, 3'b000}) + 7'({tens, 1'b0});
    assign ones      = 4'(sat_value - tens_x10);

    // Odd positions show the tens digit.
    assign segments = seg_code(digit_position[0] ? tens : ones);

endmodule

[design/two_way_traffic_phase_controller.sv]
// ----------------------------------------------------------------------------
// Two-way traffic phase controller
// Path: an accepted item is held in the input register, then its result in the
// result register, where it waits until the receiver takes it.
// Throughput: one item per cycle while the result side is not stalled, with the
// sequencer update between the two registers.
// Reset: both sequencers restart (east-west red, north-south green), counts
// and held values clear, and the durations return to their defaults.
// ----------------------------------------------------------------------------
module two_way_traffic_phase_controller
    import twtp_pkg::*;
#(
    parameter int TIME_BITS = 7
)
(
    input  logic        clk,
    input  logic        rst_n,
    // Input stream: s_tdata = digit_position[2:0], zero pad[7:3]
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,
    // s_tuser = command[0]
    input  logic        s_tuser,
    // Result stream: m_tdata = ew_remaining[7:0], ns_remaining[15:8],
    // ew_phase_out[17:16], ns_phase_out[19:18], ew_lamps[24:20],
    // ns_lamps[29:25], segments[36:30], reload_waiting[37], zero pad[39:38]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int COUNT_BITS = TIME_BITS + 1;
    localparam int WIDE_BITS  = (COUNT_BITS > 8) ? COUNT_BITS : 8;

    logic                                in_valid_reg;
    logic                                in_valid_next;
    logic                                cmd_reg;
    logic [2:0]                          pos_reg;
    logic                                out_valid_reg;
    logic                                out_valid_next;
    logic [39:0]                         out_data_reg;
    logic [39:0]                         out_data_next;
    logic                                pending_reg;
    logic                                pending_next;
    logic                                advance;
    logic                                process;
    logic                                tick;
    logic                                load;
    logic [NUM_TIMES-1:0][TIME_BITS-1:0] active;
    phase_t                              ew_phase;
    phase_t                              ns_phase;
    phase_t                              ew_phase_now;
    phase_t                              ns_phase_now;
    logic [COUNT_BITS-1:0]               ew_rem_now;
    logic [COUNT_BITS-1:0]               ns_rem_now;
    logic                                ew_zero;
    logic                                ns_zero;
    logic [WIDE_BITS-1:0]                ew_rem_wide;
    logic [WIDE_BITS-1:0]                ns_rem_wide;
    logic [6:0]                          segments;

    // Handshake: the input register moves on whenever the result slot frees.
    assign advance  = !out_valid_reg || m_tready;
    assign process  = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign tick     = process && (cmd_reg == CMD_TICK);
    assign pready   = 1'b1;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready)
        begin
            in_valid_next = 1'b1;
        end
        else if (process)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (process)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            cmd_reg <= s_tuser;
            pos_reg <= s_tdata[2:0];
        end
    end

    // Duration registers and active copy.
    twtp_regs #(
        .TIME_BITS (TIME_BITS)
    ) u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .load    (load),
        .active  (active)
    );

    // One sequencer per direction.
    twtp_sequencer #(
        .TIME_BITS   (TIME_BITS),
        .RESET_PHASE (PH_RED)
    ) u_ew_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (tick),
        .times      (active[3:0]),
        .phase      (ew_phase),
        .phase_now  (ew_phase_now),
        .rem_now    (ew_rem_now),
        .count_zero (ew_zero)
    );

    twtp_sequencer #(
        .TIME_BITS   (TIME_BITS),
        .RESET_PHASE (PH_GREEN)
    ) u_ns_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (tick),
        .times      (active[7:4]),
        .phase      (ns_phase),
        .phase_now  (ns_phase_now),
        .rem_now    (ns_rem_now),
        .count_zero (ns_zero)
    );

    // Reload takes effect after a tick that leaves both counters at zero.
    assign load = tick && pending_reg && ew_zero && ns_zero;

    always_comb
    begin
        pending_next = pending_reg;
        if (process && (cmd_reg == CMD_RELOAD))
        begin
            pending_next = 1'b1;
        end
        else if (load)
        begin
            pending_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 1'b0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    // Scanned display digit.
    twtp_display #(
        .VALUE_BITS (COUNT_BITS)
    ) u_display (
        .ew_value       (ew_rem_now),
        .ns_value       (ns_rem_now),
        .digit_position (pos_reg),
        .segments       (segments)
    );

    // Result packing.
    assign ew_rem_wide = WIDE_BITS'(ew_rem_now);
    assign ns_rem_wide = WIDE_BITS'(ns_rem_now);

    always_comb
    begin
        out_data_next        = '0;
        out_data_next[7:0]   = ew_rem_wide[7:0];
        out_data_next[15:8]  = ns_rem_wide[7:0];
        out_data_next[17:16] = phase_code(ew_phase_now);
        out_data_next[19:18] = phase_code(ns_phase_now);
        out_data_next[24:20] = phase_lamps(ew_phase_now);
        out_data_next[29:25] = phase_lamps(ns_phase_now);
        out_data_next[36:30] = segments;
        out_data_next[37]    = pending_next;
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (process)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // A reload request always shows up as a pending reload in its result.
    a_reload_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (process && (cmd_reg == CMD_RELOAD)) |=> (m_tvalid && m_tdata[37]))
        else $error("reload request not reported as pending");

    // Sequencers move only when a tick is processed.
    a_phase_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !tick |=> ($stable(ew_phase) && $stable(ns_phase)))
        else $error("phase changed without a tick");

    // An empty result slot never blocks the input side.
    a_no_block: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty result register");

    // Active durations reload only when a pending reload clears.
    a_load_clears: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> !pending_reg)
        else $error("reload pending after durations were loaded");

endmodule
